[hdl/pds_pkg.sv]
package pds_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int LENGTH_BITS_DEF = 8;
  localparam int TYPE_W          = 3;
  localparam int MODE_W          = 2;
  localparam int PRIO_W          = 2;

  localparam logic [TYPE_W-1:0] PT_WHOLE     = 3'd0;
  localparam logic [TYPE_W-1:0] PT_LETTER    = 3'd1;
  localparam logic [TYPE_W-1:0] PT_DELIMITER = 3'd2;
  localparam logic [TYPE_W-1:0] PT_START     = 3'd3;
  localparam logic [TYPE_W-1:0] PT_MID       = 3'd4;
  localparam logic [TYPE_W-1:0] PT_END       = 3'd5;

  localparam logic [MODE_W-1:0] MODE_TYPE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TYPE_LEN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEN_TYPE = 2'd2;

  localparam logic [PRIO_W-1:0] PRIO_START = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_END   = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_MID   = 2'd2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic store;
    logic latch_mode;
    logic rd_issue;
    logic pop;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic rd_pending;
    logic sort_done;
    logic chain_empty;
  } sts_t;

endpackage

[hdl/pds_entry_if.sv]
interface pds_entry_if #(
  parameter int LEN_W = pds_pkg::LENGTH_BITS_DEF
);
  import pds_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] part_type;
  logic [LEN_W-1:0]  value_length;
  logic              last_in;

  modport source (output valid, part_type, value_length, last_in, input ready);
  modport sink   (input valid, part_type, value_length, last_in, output ready);
endinterface

[hdl/pds_result_if.sv]
interface pds_result_if #(
  parameter int IDX_W = $clog2(pds_pkg::MAX_ENTRIES_DEF),
  parameter int LEN_W = pds_pkg::LENGTH_BITS_DEF
);
  import pds_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  original_index;
  logic [TYPE_W-1:0] type_out;
  logic [LEN_W-1:0]  length_out;
  logic              last_out;

  modport source (output valid, original_index, type_out, length_out, last_out, input ready);
  modport sink   (input valid, original_index, type_out, length_out, last_out, output ready);
endinterface

[hdl/pds_cfg_if.sv]
interface pds_cfg_if;
  import pds_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] sort_mode;

  modport source (output valid, sort_mode, input ready);
  modport sink   (input valid, sort_mode, output ready);
endinterface

[hdl/pds_ctrl.sv]
module pds_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output pds_pkg::cmd_t cmd,
  input  pds_pkg::sts_t sts
);
  import pds_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_valid && in_last) state_next = ST_SORT;
      end
      ST_SORT: begin
        if (sts.sort_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.chain_empty) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready       = 1'b1;
        cmd.store      = in_valid;
        cmd.latch_mode = in_valid && in_last;
      end
      ST_SORT: begin
        cmd.rd_issue = sts.rd_pending;
        cmd.clear    = sts.sort_done;
      end
      ST_EMIT: begin
        out_valid = !sts.chain_empty;
        cmd.pop   = !sts.chain_empty && out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[hdl/pds_chain.sv]
module pds_chain #(
  parameter int N  = pds_pkg::MAX_ENTRIES_DEF,
  parameter int IW = $clog2(pds_pkg::MAX_ENTRIES_DEF),
  parameter int LW = pds_pkg::LENGTH_BITS_DEF,
  parameter int KW = pds_pkg::LENGTH_BITS_DEF + 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ins,
  input  logic [KW-1:0]             ins_key,
  input  logic [IW-1:0]             ins_idx,
  input  logic [pds_pkg::TYPE_W-1:0] ins_type,
  input  logic [LW-1:0]             ins_len,
  input  logic                      pop,
  output logic [IW-1:0]             head_idx,
  output logic [pds_pkg::TYPE_W-1:0] head_type,
  output logic [LW-1:0]             head_len,
  output logic                      head_last,
  output logic                      empty
);
  import pds_pkg::*;

  localparam int CW = $clog2(N + 1);

  logic [KW-1:0]     key_q  [N];
  logic [IW-1:0]     idx_q  [N];
  logic [TYPE_W-1:0] type_q [N];
  logic [LW-1:0]     len_q  [N];
  logic [CW-1:0]     count;
  logic [N-1:0]      keep;

  // A cell keeps its contents on insertion when it holds an item that sorts
  // at or before the new one, so equal keys stay in arrival order.
  always_comb begin
    for (int j = 0; j < N; j++) begin
      keep[j] = (CW'(j) < count) && (key_q[j] <= ins_key);
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_cell
    always_ff @(posedge clk) begin
      if (ins && !keep[j]) begin
        if (j == 0) begin
          key_q[j]  <= ins_key;
          idx_q[j]  <= ins_idx;
          type_q[j] <= ins_type;
          len_q[j]  <= ins_len;
        end else if (keep[(j > 0) ? j - 1 : 0]) begin
          key_q[j]  <= ins_key;
          idx_q[j]  <= ins_idx;
          type_q[j] <= ins_type;
          len_q[j]  <= ins_len;
        end else begin
          key_q[j]  <= key_q[(j > 0) ? j - 1 : 0];
          idx_q[j]  <= idx_q[(j > 0) ? j - 1 : 0];
          type_q[j] <= type_q[(j > 0) ? j - 1 : 0];
          len_q[j]  <= len_q[(j > 0) ? j - 1 : 0];
        end
      end else if (pop && (j < N - 1)) begin
        key_q[j]  <= key_q[(j < N - 1) ? j + 1 : j];
        idx_q[j]  <= idx_q[(j < N - 1) ? j + 1 : j];
        type_q[j] <= type_q[(j < N - 1) ? j + 1 : j];
        len_q[j]  <= len_q[(j < N - 1) ? j + 1 : j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ins) begin
      count <= count + CW'(1);
    end else if (pop) begin
      count <= count - CW'(1);
    end
  end

  assign head_idx  = idx_q[0];
  assign head_type = type_q[0];
  assign head_len  = len_q[0];
  assign head_last = (count == CW'(1));
  assign empty     = (count == '0);

endmodule

[hdl/pds_datapath.sv]
module pds_datapath #(
  parameter int MAX_ENTRIES = pds_pkg::MAX_ENTRIES_DEF,
  parameter int LENGTH_BITS = pds_pkg::LENGTH_BITS_DEF,
  parameter int IW          = $clog2(pds_pkg::MAX_ENTRIES_DEF)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pds_pkg::cmd_t              cmd,
  output pds_pkg::sts_t              sts,
  input  logic                       cfg_we,
  input  logic [pds_pkg::MODE_W-1:0] cfg_data,
  input  logic [pds_pkg::TYPE_W-1:0] in_type,
  input  logic [LENGTH_BITS-1:0]     in_len,
  output logic [IW-1:0]              out_idx,
  output logic [pds_pkg::TYPE_W-1:0] out_type,
  output logic [LENGTH_BITS-1:0]     out_len,
  output logic                       out_last
);
  import pds_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = TYPE_W + LENGTH_BITS;
  localparam int KW = 1 + PRIO_W + LENGTH_BITS;

  logic [EW-1:0]          mem [MAX_ENTRIES];
  logic [CW-1:0]          entry_count;
  logic [MODE_W-1:0]      sort_mode;
  logic [MODE_W-1:0]      mode_lat;
  logic [CW-1:0]          rd_ptr;
  logic                   rd_valid;
  logic [IW-1:0]          rd_idx;
  logic [EW-1:0]          rd_word;
  logic [TYPE_W-1:0]      rd_type;
  logic [LENGTH_BITS-1:0] rd_len;
  logic [LENGTH_BITS-1:0] inv_len;
  logic [PRIO_W-1:0]      prio;
  logic                   is_sorted;
  logic                   is_known;
  logic [KW-1:0]          key;
  logic                   room;
  logic                   chain_empty;

  assign room = (entry_count < CW'(MAX_ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_mode <= MODE_TYPE;
    end else if (cfg_we) begin
      sort_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_mode) begin
      mode_lat <= sort_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.clear) begin
      entry_count <= '0;
    end else if (cmd.store && room) begin
      entry_count <= entry_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && room) begin
      mem[entry_count[IW-1:0]] <= {in_type, in_len};
    end
    if (cmd.rd_issue) begin
      rd_word <= mem[rd_ptr[IW-1:0]];
      rd_idx  <= rd_ptr[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr   <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_issue;
      if (cmd.latch_mode) begin
        rd_ptr <= '0;
      end else if (cmd.rd_issue) begin
        rd_ptr <= rd_ptr + CW'(1);
      end
    end
  end

  assign rd_type = rd_word[EW-1:LENGTH_BITS];
  assign rd_len  = rd_word[LENGTH_BITS-1:0];
  assign inv_len = ~rd_len;

  always_comb begin
    is_sorted = (rd_type == PT_START) || (rd_type == PT_MID) || (rd_type == PT_END);
    is_known  = (rd_type <= PT_END);
    if (rd_type == PT_START) begin
      prio = PRIO_START;
    end else if (rd_type == PT_END) begin
      prio = PRIO_END;
    end else begin
      prio = PRIO_MID;
    end
    // Front entries all share the zero key, so they lead in load order.
    key = '0;
    if (is_sorted) begin
      case (mode_lat)
        MODE_TYPE_LEN: key = {1'b1, prio, inv_len};
        MODE_LEN_TYPE: key = {1'b1, inv_len, prio};
        default:       key = {1'b1, {LENGTH_BITS{1'b0}}, prio};
      endcase
    end
  end

  pds_chain #(
    .N  (MAX_ENTRIES),
    .IW (IW),
    .LW (LENGTH_BITS),
    .KW (KW)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ins       (rd_valid && is_known),
    .ins_key   (key),
    .ins_idx   (rd_idx),
    .ins_type  (rd_type),
    .ins_len   (rd_len),
    .pop       (cmd.pop),
    .head_idx  (out_idx),
    .head_type (out_type),
    .head_len  (out_len),
    .head_last (out_last),
    .empty     (chain_empty)
  );

  assign sts.rd_pending  = (rd_ptr != entry_count);
  assign sts.sort_done   = (rd_ptr == entry_count) && !rd_valid;
  assign sts.chain_empty = chain_empty;

endmodule

[hdl/part_dictionary_reorder_sorter.sv]
// Dictionary reorder sorter.
// The entry channel loads one dictionary entry per cycle (part type, value
// length, last marker) while the block is loading. Entries past the storage
// depth are dropped, but a last marker on one still closes the dictionary.
// After the last entry the block reads its entry store back once, one entry a
// cycle, and inserts each into a sorted chain of registers: whole, letter and
// delimiter entries first in load order, then start, end and mid entries
// ordered by the sort mode, ties in load order. Unknown types are discarded.
// The sort pass is paced by the single read port of the entry store and its
// read register; the first result is offered in the cycle after the pass
// ends. Results then leave the result channel at one item per cycle while the
// receiver is ready, with last_out on the final one.
// While results wait the entry channel is not ready; a stalled receiver simply
// holds the chain head. The cfg channel is always ready and its sort mode is
// sampled when the last entry is accepted. Reset empties the store and the
// chain and sets the sort mode to zero.
module part_dictionary_reorder_sorter #(
  parameter int MAX_ENTRIES = pds_pkg::MAX_ENTRIES_DEF,
  parameter int LENGTH_BITS = pds_pkg::LENGTH_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  pds_entry_if.sink  entry,
  pds_result_if.source result,
  pds_cfg_if.sink    cfg
);
  import pds_pkg::*;

  localparam int IW = $clog2(MAX_ENTRIES);

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  pds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (entry.valid),
    .in_last   (entry.last_in),
    .in_ready  (entry.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  pds_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .LENGTH_BITS (LENGTH_BITS),
    .IW          (IW)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.sort_mode),
    .in_type  (entry.part_type),
    .in_len   (entry.value_length),
    .out_idx  (result.original_index),
    .out_type (result.type_out),
    .out_len  (result.length_out),
    .out_last (result.last_out)
  );

endmodule
